@@ rtl/mmp_pkg.sv @@
// Package with the shared types and constants of the matrix power unit.
`timescale 1ns / 1ps
`default_nettype none
package mmp_pkg;
  localparam int DIM = 8;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W = 3;
  localparam int CELLS = DIM * DIM;
  localparam int ADDR_W = 6;
  localparam int EXP_W = 63;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_POW = 2'd3;

  // Matrix slots held in the element memory.
  localparam logic [2:0] SLOT_A = 3'd0;
  localparam logic [2:0] SLOT_B = 3'd1;
  localparam logic [2:0] SLOT_BASE = 3'd2;
  localparam logic [2:0] SLOT_ACC = 3'd3;
  localparam logic [2:0] SLOT_TEMP = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] row;
    logic [2:0] col;
    logic [31:0] value;
    logic [62:0] exponent;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_row;
    logic [2:0] out_col;
    logic [31:0] out_value;
    logic last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_CHECK, ST_MUL, ST_COPY, ST_SHIFT, ST_EMIT, ST_EMIT_WAIT
  } state_t;

  // Request from the sequencer to the datapath.
  typedef struct packed {
    logic start_mul;
    logic [2:0] src_x;
    logic [2:0] src_y;
    logic [2:0] dst;
    logic start_copy;
    logic [2:0] copy_src;
    logic [2:0] copy_dst;
    logic ident;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;
endpackage
`default_nettype wire

@@ rtl/mmp_mem.sv @@
// Element memory holding all five working matrices.
`timescale 1ns / 1ps
`default_nettype none
module mmp_mem (
  input wire logic clk,
  input wire logic we,
  input wire logic [8:0] waddr,
  input wire logic [31:0] wdata,
  input wire logic [8:0] raddr,
  output logic [31:0] rdata
);
  logic [31:0] mem [0:511];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/mmp_datapath.sv @@
// Multiply-accumulate, copy and identity engine over the element memory.
`timescale 1ns / 1ps
`default_nettype none
module mmp_datapath (
  input wire logic clk,
  input wire logic rst,
  input wire mmp_pkg::dp_cmd_t cmd,
  output mmp_pkg::dp_sts_t sts,
  output logic mem_we,
  output logic [8:0] mem_waddr,
  output logic [31:0] mem_wdata,
  output logic [8:0] mem_raddr,
  input wire logic [31:0] mem_rdata
);
  // Phases: x read, y read, y held, accumulate. Copy: read then write.
  logic busy, is_copy, is_ident;
  logic [1:0] phase;
  logic [2:0] src_x, src_y, dst;
  logic [2:0] i, j, k;
  logic [31:0] xval, acc;
  logic [31:0] prod;
  logic row_end, cell_end, k_end;
  logic we_next, done_next;

  assign prod = xval * mem_rdata;
  assign row_end = (j == 3'(mmp_pkg::DIM - 1));
  assign cell_end = row_end && (i == 3'(mmp_pkg::DIM - 1));
  assign k_end = (k == 3'(mmp_pkg::DIM - 1));

  // The y address is kept through phases 1 and 2 so that it is on the read data
  // when the accumulate phase uses it.
  always_comb begin
    mem_raddr = {src_x, i, k};
    if (phase == 2'd1 || phase == 2'd2) mem_raddr = {src_y, k, j};
    if (is_copy) mem_raddr = {src_x, i, j};
  end

  always_comb begin
    we_next = 1'b0;
    done_next = 1'b0;
    if (busy) begin
      if (is_ident) begin
        we_next = 1'b1;
      end else if (is_copy) begin
        we_next = (phase != 2'd0);
      end else begin
        we_next = (phase == 2'd3) && k_end;
      end
      done_next = we_next && cell_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      is_copy <= 1'b0;
      is_ident <= 1'b0;
      phase <= 2'd0;
      mem_we <= 1'b0;
      sts.done <= 1'b0;
    end else begin
      mem_we <= we_next;
      sts.done <= done_next;
      if (!busy) begin
        if (cmd.start_mul || cmd.start_copy || cmd.ident) begin
          busy <= 1'b1;
          is_copy <= cmd.start_copy;
          is_ident <= cmd.ident;
          src_x <= cmd.start_copy ? cmd.copy_src : cmd.src_x;
          src_y <= cmd.src_y;
          dst <= cmd.start_copy ? cmd.copy_dst : cmd.dst;
          i <= '0; j <= '0; k <= '0; phase <= 2'd0; acc <= '0;
        end
      end else begin
        if (we_next) begin
          mem_waddr <= {dst, i, j};
          j <= row_end ? 3'd0 : j + 3'd1;
          if (row_end) i <= i + 3'd1;
        end
        if (done_next) begin
          busy <= 1'b0;
          is_copy <= 1'b0;
          is_ident <= 1'b0;
        end
        if (is_ident) begin
          mem_wdata <= (i == j) ? 32'd1 : 32'd0;
        end else if (is_copy) begin
          phase <= (phase == 2'd0) ? 2'd1 : 2'd0;
          mem_wdata <= mem_rdata;
        end else begin
          case (phase)
            2'd0: phase <= 2'd1;
            2'd1: begin
              xval <= mem_rdata;
              phase <= 2'd2;
            end
            2'd2: phase <= 2'd3;
            default: begin
              phase <= 2'd0;
              if (k_end) begin
                mem_wdata <= acc + prod;
                acc <= '0;
                k <= '0;
              end else begin
                acc <= acc + prod;
                k <= k + 3'd1;
              end
            end
          endcase
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/matrix_multiply_power_unit.sv @@
// Top level of the matrix multiply and power unit.
// Usage:
// The in channel carries transactions of type mmp_pkg::in_item_t. Loads (modes 0
// and 1) write one element of A or B and give no result; each is taken while the
// block is idle, so loads can follow back to back. Mode 2 streams out A*B, mode 3
// streams out A^exponent, as 64 out transactions in row-major order, with last
// set on the final one.
// Each multiply-accumulate of a matrix product steps through the x read, y read,
// y held and accumulate phases, set by the single read port of the element memory.
// A power first builds the identity and copies A; each exponent bit then costs up
// to two products and two copies.
// Each element is read, registered and taken before the next one is read.
// The block accepts one transaction at a time and holds in_ready low while busy.
// When the receiver stalls, the current element waits in the output register
// and the sequencer stays put until it is taken.
// Reset clears the control state only; the element memory is not cleared, and
// elements must be loaded before they are used.
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply_power_unit (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire mmp_pkg::in_item_t in_data,
  output logic out_valid,
  input wire logic out_ready,
  output mmp_pkg::out_item_t out_data
);
  mmp_pkg::state_t state, state_next;
  mmp_pkg::dp_cmd_t cmd;
  mmp_pkg::dp_sts_t sts;
  logic dp_we, mem_we;
  logic [8:0] dp_waddr, dp_raddr, mem_waddr, mem_raddr;
  logic [31:0] dp_wdata, mem_wdata, mem_rdata;
  logic [62:0] exp_reg;
  logic is_pow, sq_phase, issued;
  // The first copy after the identity moves A into the base slot.
  logic first_copy;
  logic [2:0] er, ec;
  logic emit_rd;
  logic load_we;
  logic accept;

  assign accept = in_valid && in_ready;
  assign load_we = accept && (in_data.mode == mmp_pkg::MODE_LOAD_A
                              || in_data.mode == mmp_pkg::MODE_LOAD_B);

  always_comb begin
    mem_we = dp_we;
    mem_waddr = dp_waddr;
    mem_wdata = dp_wdata;
    mem_raddr = dp_raddr;
    if (load_we) begin
      mem_we = 1'b1;
      mem_waddr = {(in_data.mode == mmp_pkg::MODE_LOAD_A) ? mmp_pkg::SLOT_A
                   : mmp_pkg::SLOT_B, in_data.row, in_data.col};
      mem_wdata = in_data.value;
    end
    if (state == mmp_pkg::ST_EMIT) begin
      mem_raddr = {is_pow ? mmp_pkg::SLOT_ACC : mmp_pkg::SLOT_TEMP, er, ec};
    end
  end

  mmp_mem u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  mmp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .mem_we(dp_we), .mem_waddr(dp_waddr), .mem_wdata(dp_wdata),
    .mem_raddr(dp_raddr), .mem_rdata(mem_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mmp_pkg::ST_IDLE: begin
        if (accept && in_data.mode == mmp_pkg::MODE_MUL) state_next = mmp_pkg::ST_MUL;
        if (accept && in_data.mode == mmp_pkg::MODE_POW) state_next = mmp_pkg::ST_INIT;
      end
      mmp_pkg::ST_INIT: if (sts.done) state_next = mmp_pkg::ST_COPY;
      mmp_pkg::ST_COPY: if (sts.done) state_next = is_pow && issued ?
                                                   mmp_pkg::ST_CHECK : mmp_pkg::ST_COPY;
      mmp_pkg::ST_CHECK: begin
        if (exp_reg == '0) state_next = mmp_pkg::ST_EMIT;
        else if (!sq_phase && exp_reg[0]) state_next = mmp_pkg::ST_MUL;
        else if (!sq_phase) state_next = mmp_pkg::ST_SHIFT;
        else state_next = mmp_pkg::ST_MUL;
      end
      mmp_pkg::ST_MUL: if (sts.done) state_next = is_pow ? mmp_pkg::ST_COPY
                                                   : mmp_pkg::ST_EMIT;
      mmp_pkg::ST_SHIFT: state_next = mmp_pkg::ST_CHECK;
      mmp_pkg::ST_EMIT: state_next = mmp_pkg::ST_EMIT_WAIT;
      mmp_pkg::ST_EMIT_WAIT: begin
        // The element in the output register carries the last flag, so the
        // matrix is finished once that element has been taken.
        if (out_valid && out_ready) begin
          state_next = out_data.last ? mmp_pkg::ST_IDLE : mmp_pkg::ST_EMIT;
        end
      end
      default: state_next = mmp_pkg::ST_IDLE;
    endcase
  end

  // Outputs towards the datapath.
  always_comb begin
    cmd = '0;
    in_ready = (state == mmp_pkg::ST_IDLE);
    case (state)
      mmp_pkg::ST_INIT: begin
        cmd.ident = !issued;
        cmd.dst = mmp_pkg::SLOT_ACC;
      end
      mmp_pkg::ST_COPY: begin
        cmd.start_copy = !issued;
        cmd.copy_src = sq_phase || !first_copy ? mmp_pkg::SLOT_TEMP
                                               : mmp_pkg::SLOT_A;
        cmd.copy_dst = !first_copy ?
                       (sq_phase ? mmp_pkg::SLOT_BASE : mmp_pkg::SLOT_ACC)
                       : mmp_pkg::SLOT_BASE;
      end
      mmp_pkg::ST_MUL: begin
        cmd.start_mul = !issued;
        cmd.dst = mmp_pkg::SLOT_TEMP;
        if (!is_pow) begin
          cmd.src_x = mmp_pkg::SLOT_A;
          cmd.src_y = mmp_pkg::SLOT_B;
        end else if (sq_phase) begin
          cmd.src_x = mmp_pkg::SLOT_BASE;
          cmd.src_y = mmp_pkg::SLOT_BASE;
        end else begin
          cmd.src_x = mmp_pkg::SLOT_ACC;
          cmd.src_y = mmp_pkg::SLOT_BASE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmp_pkg::ST_IDLE;
      issued <= 1'b0;
      out_valid <= 1'b0;
      emit_rd <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start_mul || cmd.start_copy || cmd.ident) issued <= 1'b1;
      else if (sts.done) issued <= 1'b0;
      emit_rd <= (state == mmp_pkg::ST_EMIT);
      if (emit_rd) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // Operation registers. After the accumulator copy the exponent moves on by
  // one bit and a squaring follows if bits remain; after the base copy the
  // next bit is examined.
  always_ff @(posedge clk) begin
    if (accept) begin
      is_pow <= (in_data.mode == mmp_pkg::MODE_POW);
      exp_reg <= in_data.exponent;
      sq_phase <= 1'b0;
      first_copy <= 1'b1;
      er <= '0;
      ec <= '0;
    end else if (state == mmp_pkg::ST_COPY && sts.done) begin
      first_copy <= 1'b0;
      if (!first_copy) begin
        if (sq_phase) begin
          sq_phase <= 1'b0;
        end else begin
          exp_reg <= exp_reg >> 1;
          sq_phase <= (exp_reg >> 1) != '0;
        end
      end
    end else if (state == mmp_pkg::ST_SHIFT) begin
      exp_reg <= exp_reg >> 1;
      sq_phase <= (exp_reg >> 1) != '0;
    end else if (emit_rd) begin
      out_data.out_row <= er;
      out_data.out_col <= ec;
      out_data.out_value <= mem_rdata;
      out_data.last <= (er == 3'(mmp_pkg::DIM - 1) && ec == 3'(mmp_pkg::DIM - 1));
      ec <= (ec == 3'(mmp_pkg::DIM - 1)) ? 3'd0 : ec + 3'd1;
      if (ec == 3'(mmp_pkg::DIM - 1)) er <= er + 3'd1;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != mmp_pkg::ST_IDLE) |-> !in_ready)
    else $error("input taken while busy");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> (state == mmp_pkg::ST_IDLE))
    else $error("block not idle after last element");
  a_no_emit_in_idle: assert property (@(posedge clk) disable iff (rst)
    (state == mmp_pkg::ST_IDLE) |-> !emit_rd)
    else $error("emission read while idle");
endmodule
`default_nettype wire
